### hdl/mcru_pkg.sv
// shared types and constants for the motion controller report unpacker
package mcru_pkg;

    localparam int REPORT_LENGTH_DEF = 49;
    localparam int CAP_DEPTH         = 43;
    localparam int CAP_IDX_W         = $clog2(CAP_DEPTH);
    localparam int FIFO_DEPTH        = 2;
    localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

    localparam int SEQ_BYTE     = 4;
    localparam int TRIGGER_BYTE = 6;
    localparam int BATTERY_BYTE = 12;
    localparam int ACCEL_BASE   = 13;
    localparam int GYRO_BASE    = 25;
    localparam int HALF_STRIDE  = 6;
    localparam int TEMP_BYTE    = 37;
    localparam int MAG_BYTE     = 38;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_word;
    typedef logic [11:0] t_mag;

    typedef struct packed {
        t_word [1:0][2:0] accel;
        t_word [1:0][2:0] gyro;
        t_mag  [2:0]      mag;
        logic  [3:0]      gap;
        logic  [36:0]     status;
    } t_report;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    // offset-binary little-endian word to two's complement
    function automatic t_word offset_word(input t_byte lo, input t_byte hi);
        return {~hi[7], hi[6:0], lo};
    endfunction

endpackage

### hdl/motion_controller_report_unpacker.sv
// top level: takes one report byte per cycle unless stalled, decoding a report on its last byte
// a report decodes into a two-report queue; its first result is valid once it has passed the
// queue and the output register, and the second follows in the next cycle unless the output
// stalls; sustained rate one byte per cycle while not stalled; results leave at up to one per
// cycle from the queue; input stalls only while the queue holds two reports not yet fully sent
// synchronous active-low reset clears the byte count, sequence history, queue and output valid
module motion_controller_report_unpacker
    import mcru_pkg::*;
#(
    parameter int REPORT_LENGTH = REPORT_LENGTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_report_byte,
    input  logic               i_report_start,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_half_index,
    output logic signed [15:0] o_accel_x,
    output logic signed [15:0] o_accel_y,
    output logic signed [15:0] o_accel_z,
    output logic signed [15:0] o_gyro_x,
    output logic signed [15:0] o_gyro_y,
    output logic signed [15:0] o_gyro_z,
    output logic signed [11:0] o_mag_x,
    output logic signed [11:0] o_mag_y,
    output logic signed [11:0] o_mag_z,
    output logic [3:0]         o_sequence_gap,
    output logic [36:0]        o_status_bits
);

    t_fifo_status w_fifo;
    t_report      w_push_report;
    t_report      w_head;
    logic         w_push;
    logic         w_pop;

    mcru_front #(
        .REPORT_LENGTH(REPORT_LENGTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_report_byte  (i_report_byte),
        .i_report_start (i_report_start),
        .o_stall        (o_stall),
        .i_fifo         (w_fifo),
        .o_push         (w_push),
        .o_report       (w_push_report)
    );

    mcru_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_report (w_push_report),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_fifo)
    );

    mcru_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_fifo         (w_fifo),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_half_index   (o_half_index),
        .o_accel_x      (o_accel_x),
        .o_accel_y      (o_accel_y),
        .o_accel_z      (o_accel_z),
        .o_gyro_x       (o_gyro_x),
        .o_gyro_y       (o_gyro_y),
        .o_gyro_z       (o_gyro_z),
        .o_mag_x        (o_mag_x),
        .o_mag_y        (o_mag_y),
        .o_mag_z        (o_mag_z),
        .o_sequence_gap (o_sequence_gap),
        .o_status_bits  (o_status_bits)
    );

endmodule

### hdl/mcru_front.sv
// byte intake: position count, byte capture, sequence tracking and report decode
module mcru_front
    import mcru_pkg::*;
#(
    parameter int REPORT_LENGTH = REPORT_LENGTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [7:0]   i_report_byte,
    input  logic         i_report_start,
    output logic         o_stall,
    input  t_fifo_status i_fifo,
    output logic         o_push,
    output t_report      o_report
);

    localparam int POS_W = $clog2(REPORT_LENGTH);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(REPORT_LENGTH - 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [3:0]       r_prev_seq, n_prev_seq;
    logic             r_primed, n_primed;
    t_byte            r_cap [CAP_DEPTH];

    logic [POS_W-1:0] w_pos;
    logic             w_accept;
    logic             w_last;
    logic [3:0]       w_seq;
    logic [8:0]       w_buttons;
    logic [11:0]      w_temp;

    assign o_stall  = i_fifo.full;
    assign w_accept = i_valid && !i_fifo.full;
    assign w_pos    = i_report_start ? '0 : r_pos;
    assign w_last   = (w_pos == LAST_POS);
    assign w_seq    = r_cap[SEQ_BYTE][3:0];
    assign o_push   = w_accept && w_last && r_primed;

    always_comb begin
        n_pos      = r_pos;
        n_prev_seq = r_prev_seq;
        n_primed   = r_primed;
        if (w_accept) begin
            n_pos = w_last ? '0 : w_pos + 1'b1;
            if (w_last) begin
                n_prev_seq = w_seq;
                n_primed   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_prev_seq <= '0;
            r_primed   <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_prev_seq <= n_prev_seq;
            r_primed   <= n_primed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (32'(w_pos) < CAP_DEPTH)) begin
            r_cap[w_pos[CAP_IDX_W-1:0]] <= i_report_byte;
        end
    end

    assign w_buttons = {r_cap[3][4], r_cap[3][3], r_cap[3][0],
                        r_cap[2][7], r_cap[2][6], r_cap[2][5], r_cap[2][4],
                        r_cap[1][3], r_cap[1][0]};
    assign w_temp    = {r_cap[TEMP_BYTE], r_cap[MAG_BYTE][7:4]};

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            for (int i = 0; i < 3; i++) begin
                o_report.accel[h][i] =
                    offset_word(r_cap[ACCEL_BASE + HALF_STRIDE*h + 2*i],
                                r_cap[ACCEL_BASE + HALF_STRIDE*h + 2*i + 1]);
                o_report.gyro[h][i] =
                    offset_word(r_cap[GYRO_BASE + HALF_STRIDE*h + 2*i],
                                r_cap[GYRO_BASE + HALF_STRIDE*h + 2*i + 1]);
            end
        end
        o_report.mag[0] = {r_cap[MAG_BYTE][3:0], r_cap[MAG_BYTE+1]};
        o_report.mag[1] = {r_cap[MAG_BYTE+2], r_cap[MAG_BYTE+3][7:4]};
        o_report.mag[2] = {r_cap[MAG_BYTE+3][3:0], r_cap[MAG_BYTE+4]};
        o_report.gap    = w_seq - r_prev_seq;
        o_report.status = {w_temp, r_cap[BATTERY_BYTE], r_cap[TRIGGER_BYTE], w_buttons};
    end

endmodule

### hdl/mcru_fifo.sv
// two-entry queue of decoded reports between intake and result output
module mcru_fifo
    import mcru_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_report      i_report,
    input  logic         i_pop,
    output t_report      o_head,
    output t_fifo_status o_status
);

    t_report                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr, n_wr;
    logic [FIFO_PTR_W-1:0]  r_rd, n_rd;
    logic [FIFO_CNT_W-1:0]  r_count, n_count;

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = i_pop  ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_report;
        end
    end

endmodule

### hdl/mcru_back.sv
// result output: splits each queued report into two half-sample transfers
module mcru_back
    import mcru_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_report            i_head,
    input  t_fifo_status       i_fifo,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_half_index,
    output logic signed [15:0] o_accel_x,
    output logic signed [15:0] o_accel_y,
    output logic signed [15:0] o_accel_z,
    output logic signed [15:0] o_gyro_x,
    output logic signed [15:0] o_gyro_y,
    output logic signed [15:0] o_gyro_z,
    output logic signed [11:0] o_mag_x,
    output logic signed [11:0] o_mag_y,
    output logic signed [11:0] o_mag_z,
    output logic [3:0]         o_sequence_gap,
    output logic [36:0]        o_status_bits
);

    logic             r_valid, n_valid;
    logic             r_half, n_half;
    logic             r_out_half;
    t_word [2:0]      r_accel;
    t_word [2:0]      r_gyro;
    t_mag  [2:0]      r_mag;
    logic [3:0]       r_gap;
    logic [36:0]      r_status;
    logic             w_load;

    assign w_load = !i_fifo.empty && (!r_valid || !i_stall);
    assign o_pop  = w_load && r_half;

    always_comb begin
        n_valid = r_valid;
        n_half  = r_half;
        if (w_load) begin
            n_valid = 1'b1;
            n_half  = ~r_half;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_half <= r_half;
            r_accel    <= i_head.accel[r_half];
            r_gyro     <= i_head.gyro[r_half];
            r_mag      <= i_head.mag;
            r_gap      <= i_head.gap;
            r_status   <= i_head.status;
        end
    end

    assign o_valid        = r_valid;
    assign o_half_index   = r_out_half;
    assign o_accel_x      = signed'(r_accel[0]);
    assign o_accel_y      = signed'(r_accel[1]);
    assign o_accel_z      = signed'(r_accel[2]);
    assign o_gyro_x       = signed'(r_gyro[0]);
    assign o_gyro_y       = signed'(r_gyro[1]);
    assign o_gyro_z       = signed'(r_gyro[2]);
    assign o_mag_x        = signed'(r_mag[0]);
    assign o_mag_y        = signed'(r_mag[1]);
    assign o_mag_z        = signed'(r_mag[2]);
    assign o_sequence_gap = r_gap;
    assign o_status_bits  = r_status;

endmodule

### hdl/mcru_checker.sv
// port-level checks for the report unpacker and their bind to the top level
module mcru_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_half_index,
    input logic signed [15:0] o_accel_x,
    input logic signed [15:0] o_accel_y,
    input logic signed [15:0] o_accel_z,
    input logic signed [15:0] o_gyro_x,
    input logic signed [15:0] o_gyro_y,
    input logic signed [15:0] o_gyro_z,
    input logic signed [11:0] o_mag_x,
    input logic signed [11:0] o_mag_y,
    input logic signed [11:0] o_mag_z,
    input logic [3:0]         o_sequence_gap,
    input logic [36:0]        o_status_bits
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_half_index)
            && $stable(o_accel_x) && $stable(o_accel_y) && $stable(o_accel_z)
            && $stable(o_gyro_x) && $stable(o_gyro_y) && $stable(o_gyro_z)
            && $stable(o_mag_x) && $stable(o_mag_y) && $stable(o_mag_z)
            && $stable(o_sequence_gap) && $stable(o_status_bits)))
        else $error("stalled result changed");

    // second half follows right after the first half's transfer
    a_half_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_half_index) |=> (o_valid && o_half_index))
        else $error("second half did not follow first half");

    // a fresh second half only appears after a first half transfer
    a_half_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_half_index && !($past(o_valid) && $past(o_half_index)))
            |-> $past(o_valid && !o_half_index && !i_stall))
        else $error("second half without first half");

    // reset leaves no result pending and the input open
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("reset left output valid or input stalled");

endmodule

bind motion_controller_report_unpacker mcru_checker u_mcru_checker (.*);
